@@ rtl/uutf_pkg.sv @@
// Package with the encoding codes, result type and transcoding functions of the UTF transcoder.
`default_nettype none

package uutf_pkg;

  // Encoding codes of the source and target format registers; code three reads as UTF-32.
  typedef enum logic [1:0] {
    FMT_UTF8  = 2'd0,
    FMT_UTF16 = 2'd1,
    FMT_UTF32 = 2'd2
  } fmt_e;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_SOURCE_FORMAT = 1'b0,
    REG_TARGET_FORMAT = 1'b1
  } reg_idx_e;

  localparam logic [31:0] MaxScalar   = 32'h0010_FFFF;
  localparam logic [20:0] Replacement = 21'h00_FFFD;
  localparam logic [20:0] SuppBase    = 21'h01_0000;

  // Marker bits of UTF-8 lead and continuation bytes and of UTF-16 surrogates.
  localparam logic [2:0] Utf8Lead2   = 3'b110;
  localparam logic [3:0] Utf8Lead3   = 4'b1110;
  localparam logic [4:0] Utf8Lead4   = 5'b11110;
  localparam logic [1:0] Utf8Cont    = 2'b10;
  localparam logic [5:0] HiSurrogate = 6'b110110;
  localparam logic [5:0] LoSurrogate = 6'b110111;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  units;
  } enc_t;

  // Decodes one packed character into its scalar value. Values above the Unicode range
  // become the replacement character.
  function automatic logic [20:0] decode_cp(fmt_e fmt, logic [31:0] w);
    logic [31:0] cp;
    case (fmt)
      FMT_UTF8: begin
        // The highest nonzero byte is the lead byte and sets the sequence length.
        if (w[31:24] != 8'd0) begin
          cp = {11'd0, w[26:24], w[21:16], w[13:8], w[5:0]};
        end else if (w[23:16] != 8'd0) begin
          cp = {16'd0, w[19:16], w[13:8], w[5:0]};
        end else if (w[15:8] != 8'd0) begin
          cp = {21'd0, w[12:8], w[5:0]};
        end else begin
          cp = {24'd0, w[7:0]};
        end
      end
      FMT_UTF16: begin
        // A zero high half means a single unit, taken as is.
        if (w[31:16] == 16'd0) begin
          cp = {16'd0, w[15:0]};
        end else begin
          cp = {11'd0, SuppBase} + {12'd0, w[25:16], w[9:0]};
        end
      end
      default: begin
        cp = w;
      end
    endcase
    if (cp > MaxScalar) begin
      return Replacement;
    end
    return cp[20:0];
  endfunction

  // Encodes a scalar value into packed code units of the target format.
  function automatic enc_t encode_cp(fmt_e fmt, logic [20:0] cp);
    enc_t        r;
    logic [20:0] v;
    v = cp - SuppBase;
    r.word  = {11'd0, cp};
    r.units = 3'd1;
    case (fmt)
      FMT_UTF8: begin
        if (cp < 21'h80) begin
          r.word  = {11'd0, cp};
          r.units = 3'd1;
        end else if (cp < 21'h800) begin
          r.word  = {16'd0, Utf8Lead2, cp[10:6], Utf8Cont, cp[5:0]};
          r.units = 3'd2;
        end else if (cp < SuppBase) begin
          r.word  = {8'd0, Utf8Lead3, cp[15:12], Utf8Cont, cp[11:6], Utf8Cont, cp[5:0]};
          r.units = 3'd3;
        end else begin
          r.word  = {Utf8Lead4, cp[20:18], Utf8Cont, cp[17:12], Utf8Cont, cp[11:6],
                     Utf8Cont, cp[5:0]};
          r.units = 3'd4;
        end
      end
      FMT_UTF16: begin
        // Surrogate-range values are written out like any other BMP value.
        if (cp < SuppBase) begin
          r.word  = {11'd0, cp};
          r.units = 3'd1;
        end else begin
          r.word  = {HiSurrogate, v[19:10], LoSurrogate, v[9:0]};
          r.units = 3'd2;
        end
      end
      default: begin
        r.word  = {11'd0, cp};
        r.units = 3'd1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/unicode_utf_transcoder.sv @@
// Top level of the UTF-8 / UTF-16 / UTF-32 single-character transcoder.
`default_nettype none

// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata[31:0] in_word
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata[31:0] out_word,
//           |           |                              |   [34:32] out_units, [55:35] code_point
// cfg       | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i[1:0]
//
// The block takes one word per cycle while the result side does not stall. Each word
// passes through the input register and then the result register; the decode and
// re-encode of a character is a single pass of logic between them.
// Reset clears both valid flags and sets the formats to UTF-8 in and UTF-32 out.
// A stall on the result side holds the result register; the input register keeps taking a
// word as long as it is empty or its word moves on into the result register that cycle.
// The format registers are meant to be written only while no word is in flight.
module unicode_utf_transcoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] in_word
  // Result channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [31:0] out_word, [34:32] out_units,
                                           // [55:35] code_point
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_data_i
);
  import uutf_pkg::*;

  fmt_e        src_fmt_q, src_fmt_d;
  fmt_e        dst_fmt_q, dst_fmt_d;

  logic        in_valid_q, in_valid_d;
  logic [31:0] in_word_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q;
  logic [2:0]  out_units_q;
  logic [20:0] out_cp_q;

  logic        in_take;    // a word enters the input register
  logic        out_ready;  // the result register can take a new result
  logic        out_load;   // the word in the input register moves on
  logic [20:0] cp;
  enc_t        enc;

  // Format registers: only the two low bits of the data are kept, so code three can be
  // stored and is then handled as UTF-32.
  always_comb begin
    src_fmt_d = src_fmt_q;
    dst_fmt_d = dst_fmt_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SOURCE_FORMAT: src_fmt_d = fmt_e'(cfg_data_i);
        REG_TARGET_FORMAT: dst_fmt_d = fmt_e'(cfg_data_i);
        default: begin
          src_fmt_d = src_fmt_q;
        end
      endcase
    end
  end

  // Two-register pipeline with flow control passed back one stage per register.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign out_load      = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take || (in_valid_q && !out_ready);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  // Decode to a scalar value, then re-encode it in the target format.
  assign cp  = decode_cp(src_fmt_q, in_word_q);
  assign enc = encode_cp(dst_fmt_q, cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q   <= FMT_UTF8;
      dst_fmt_q   <= FMT_UTF32;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      src_fmt_q   <= src_fmt_d;
      dst_fmt_q   <= dst_fmt_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_word_q  <= enc.word;
      out_units_q <= enc.units;
      out_cp_q    <= cp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cp_q, out_units_q, out_word_q};

  // A held word is never dropped while the result register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_ready |=> in_valid_q)
    else $error("input word lost during a result stall");

  // The input side is only closed when the input register holds a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input blocked with an empty input register");

  // Every delivered result has one to four units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_units_q >= 3'd1 && out_units_q <= 3'd4))
    else $error("unit count out of range");

  // Every delivered scalar lies within the Unicode range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({11'd0, out_cp_q} <= MaxScalar))
    else $error("scalar value above the Unicode range");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the UTF-8 / UTF-16 / UTF-32 single-character transcoder.
`timescale 1ns / 1ps

module testbench;
  import uutf_pkg::*;

  // Register value three is not in the encoding enum; the block reads it as UTF-32.
  localparam logic [1:0]  FMT_CODE_THREE   = 2'd3;
  localparam logic [31:0] LAST_SCALAR      = 32'h0010_FFFF;
  localparam logic [31:0] REPLACEMENT_CHAR = 32'h0000_FFFD;
  localparam logic [20:0] SUPP_PLANE_BASE  = 21'h01_0000;
  // Two register stages between the input and the result channel.
  localparam int          PIPE_LATENCY     = 2;
  localparam int          HOLD_OFF_CYCLES  = 300;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          RANDOM_PER_PAIR  = 78;
  localparam int          MAX_ERROR_LINES  = 40;

  // One result word as it sits on m_axis_tdata: out_word lowest, code_point highest.
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  units;
    logic [31:0] word;
  } char_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [1:0]  cfg_data_i;

  // Our own copy of the two format registers, updated whenever we write them.
  logic [1:0]   src_fmt;
  logic [1:0]   dst_fmt;
  char_result_t expected_chars[$];

  int  mismatches;
  int  words_sent;
  int  results_checked;
  int  format_pairs;
  int  idle_cycles;
  bit  sender_gaps_on;
  bit  rx_stalls_on;
  bit  hold_off_req;

  unicode_utf_transcoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Turns packed code units into a scalar value. In UTF-8 the highest nonzero byte is the
  // lead and sets the length; its marker bits are dropped by masking, never checked.
  // Anything above the Unicode range, from any source, becomes the replacement character.
  function automatic logic [20:0] decode_char(logic [1:0] fmt, logic [31:0] w);
    logic [31:0] cp;
    logic [7:0]  lead;
    int          top;
    top = 0;
    if (fmt == FMT_UTF8) begin
      for (int i = 0; i < 4; i++) begin
        if (w[8*i +: 8] != 8'd0) top = i;
      end
      if (top == 0) begin
        // A lone byte is taken as is, even at 0x80 and above.
        cp = {24'd0, w[7:0]};
      end else begin
        lead = w[8*top +: 8];
        case (top)
          1:       cp = {24'd0, lead & 8'h1F};
          2:       cp = {24'd0, lead & 8'h0F};
          default: cp = {24'd0, lead & 8'h07};
        endcase
        for (int i = top; i > 0; i--) begin
          cp = (cp << 6) | {26'd0, w[8*(i-1) +: 6]};
        end
      end
    end else if (fmt == FMT_UTF16) begin
      // A zero high half means a single unit, surrogate values included.
      if (w[31:16] == 16'd0) begin
        cp = {16'd0, w[15:0]};
      end else begin
        cp = 32'h0001_0000 + {12'd0, w[25:16], w[9:0]};
      end
    end else begin
      cp = w;
    end
    if (cp > LAST_SCALAR) cp = REPLACEMENT_CHAR;
    return cp[20:0];
  endfunction

  // Writes a scalar value out in the given encoding. Surrogate values are treated as
  // ordinary BMP values.
  function automatic char_result_t encode_char(logic [1:0] fmt, logic [20:0] cp);
    char_result_t r;
    logic [20:0]  v;
    v            = cp - SUPP_PLANE_BASE;
    r.code_point = cp;
    r.units      = 3'd1;
    r.word       = {11'd0, cp};
    if (fmt == FMT_UTF8) begin
      if (cp < 21'h80) begin
        r.units = 3'd1;
      end else if (cp < 21'h800) begin
        r.units = 3'd2;
        r.word  = {16'd0, 8'hC0 | cp[10:6], 8'h80 | cp[5:0]};
      end else if (cp < SUPP_PLANE_BASE) begin
        r.units = 3'd3;
        r.word  = {8'd0, 8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
      end else begin
        r.units = 3'd4;
        r.word  = {8'hF0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
      end
    end else if (fmt == FMT_UTF16) begin
      if (cp >= SUPP_PLANE_BASE) begin
        r.units = 3'd2;
        r.word  = {16'hD800 | v[19:10], 16'hDC00 | v[9:0]};
      end
    end
    return r;
  endfunction

  function automatic char_result_t transcode(logic [1:0] src, logic [1:0] dst,
                                             logic [31:0] w);
    return encode_char(dst, decode_char(src, w));
  endfunction

  // Mostly a well-formed character of the source encoding, drawn from every length class,
  // the surrogate block, the class boundaries and values past the Unicode range. The rest
  // is a raw random word, which also gives every input bit both values.
  function automatic logic [31:0] random_char(logic [1:0] fmt);
    logic [20:0]  cp;
    char_result_t enc;
    if ($urandom_range(0, 99) < 15) return $urandom();
    case ($urandom_range(0, 6))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: cp = 21'($urandom_range('h800, 'hFFFF));
      3: cp = 21'($urandom_range('h1_0000, 'h10_FFFF));
      4: cp = 21'($urandom_range('hD800, 'hDFFF));
      5: begin
        case ($urandom_range(0, 9))
          0:       cp = 21'h00_0000;
          1:       cp = 21'h00_007F;
          2:       cp = 21'h00_0080;
          3:       cp = 21'h00_07FF;
          4:       cp = 21'h00_0800;
          5:       cp = 21'h00_D7FF;
          6:       cp = 21'h00_E000;
          7:       cp = 21'h00_FFFF;
          8:       cp = 21'h01_0000;
          default: cp = 21'h10_FFFF;
        endcase
      end
      default: cp = 21'($urandom());
    endcase
    enc = encode_char(fmt, cp);
    return enc.word;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_ERROR_LINES) begin
      $display("ERROR at %0t: %s is %h, expected %h", $realtime, what, got, want);
    end
  endtask

  // Every accepted result word is compared with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    char_result_t got;
    char_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch("result word with nothing pending", got.word, 32'd0);
      end else begin
        want = expected_chars.pop_front();
        if (got.word != want.word) report_mismatch("out_word", got.word, want.word);
        if (got.units != want.units) begin
          report_mismatch("out_units", {29'd0, got.units}, {29'd0, want.units});
        end
        if (got.code_point != want.code_point) begin
          report_mismatch("code_point", {11'd0, got.code_point}, {11'd0, want.code_point});
        end
      end
    end
  end

  // The run is declared dead when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result side: random stalls per word, plus one long hold-off on request.
  // ---------------------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------

  // Offers one character word, after a random gap when gaps are on, and books its expected
  // result once the block takes it. tvalid stays high across back-to-back words.
  task automatic send_char(logic [31:0] w);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_chars.push_back(transcode(src_fmt, dst_fmt, w));
    words_sent++;
  endtask

  // Stops offering words and waits until every booked result has come back, then lets the
  // pipeline settle.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Both format registers are written back to back, only with the block idle.
  task automatic set_formats(logic [1:0] src, logic [1:0] dst);
    wait_results_done();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SOURCE_FORMAT;
    cfg_data_i <= src;
    @(posedge clk_i);
    cfg_idx_i  <= REG_TARGET_FORMAT;
    cfg_data_i <= dst;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    src_fmt = src;
    dst_fmt = dst;
    format_pairs++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Runs on the reset formats, UTF-8 in and UTF-32 out: the zero word, lone high bytes,
  // every sequence length, the top scalar, a four-byte payload past the Unicode range, a
  // lead byte without proper marker bits and an encoded surrogate.
  task automatic test_reset_formats_utf8();
    logic [31:0] words [11] = '{32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_00FF,
                               32'h0000_C2A2, 32'h00E2_82AC, 32'hF09F_9880, 32'hF48F_BFBF,
                               32'hF7BF_BFBF, 32'h0000_1234, 32'h00ED_A080};
    foreach (words[i]) send_char(words[i]);
  endtask

  // UTF-16 in, UTF-8 out: a bare surrogate unit, the BMP top, surrogate pairs up to the
  // last scalar and plain ASCII.
  task automatic test_utf16_source();
    logic [31:0] words [5] = '{32'h0000_D800, 32'h0000_FFFF, 32'hD83D_DE00, 32'hDBFF_DFFF,
                              32'h0000_0041};
    set_formats(FMT_UTF16, FMT_UTF8);
    foreach (words[i]) send_char(words[i]);
  endtask

  // UTF-32 in, UTF-16 out, across the plane boundary and past the Unicode range.
  task automatic test_utf32_source_range();
    logic [31:0] words [6] = '{32'h0000_0000, 32'h0000_DFFF, 32'h0001_0000, 32'h0010_FFFF,
                              32'h0011_0000, 32'hFFFF_FFFF};
    set_formats(FMT_UTF32, FMT_UTF16);
    foreach (words[i]) send_char(words[i]);
  endtask

  // Code three on both registers must behave as UTF-32.
  task automatic test_format_code_three();
    set_formats(FMT_CODE_THREE, FMT_CODE_THREE);
    send_char(32'h0001_F600);
    send_char(32'h8000_0000);
  endtask

  // The result side holds off for a long stretch while words keep coming with no gaps,
  // so both stages fill and the input channel has to stall.
  task automatic test_receiver_hold_off();
    set_formats(FMT_UTF8, FMT_UTF16);
    sender_gaps_on = 1'b0;
    hold_off_req   = 1'b1;
    repeat (60) send_char(random_char(src_fmt));
    sender_gaps_on = 1'b1;
  endtask

  // Every pair of register values, the unnamed code included, with random characters.
  // The idling pattern rotates per pair so both sides run gap-free at times.
  task automatic test_random_mixes();
    logic [1:0] codes [4] = '{FMT_UTF8, FMT_UTF16, FMT_UTF32, FMT_CODE_THREE};
    int         pair;
    pair = 0;
    foreach (codes[s]) begin
      foreach (codes[d]) begin
        set_formats(codes[s], codes[d]);
        sender_gaps_on = pair[0];
        rx_stalls_on   = pair[1];
        repeat (RANDOM_PER_PAIR) send_char(random_char(src_fmt));
        pair++;
      end
    end
    sender_gaps_on = 1'b1;
    rx_stalls_on   = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 32'd0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_SOURCE_FORMAT;
    cfg_data_i     <= FMT_UTF8;
    src_fmt         = FMT_UTF8;
    dst_fmt         = FMT_UTF32;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    format_pairs    = 0;
    idle_cycles     = 0;
    sender_gaps_on  = 1'b1;
    rx_stalls_on    = 1'b1;
    hold_off_req    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_formats_utf8();
    test_utf16_source();
    test_utf32_source_range();
    test_format_code_three();
    test_receiver_hold_off();
    test_random_mixes();

    wait_results_done();
    repeat (8) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      report_mismatch("results still pending at the end", expected_chars.size(), 32'd0);
    end

    $display("Sent %0d characters and checked %0d results over %0d register settings,",
             words_sent, results_checked, format_pairs);
    $display("including format code three and a %0d-cycle result hold-off; %0d mismatches.",
             HOLD_OFF_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
